// ===== rtl/sqr_pkg.sv =====
`default_nettype none

package sqr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GAS_W   = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned RATIO_W = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MS   = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] PERIOD_MS_RST = 16'd200;
  localparam logic [CFG_W-1:0] HALF_MS_RST   = 16'd100;

  // Default window capacity per sensor and heater half.
  localparam int unsigned MAX_SAMPLES_DEF = 16;

  // Step counter of the shift-subtract dividers (32 quotient bits each).
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

  // Number of sensors.
  localparam int unsigned NSENS = 2;

  // Queue depth between the classifier and the accumulator.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified sample word as it travels through the queue.
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [GAS_W-1:0]  gas_a;
    logic              ok_a;
    logic [GAS_W-1:0]  gas_b;
    logic              ok_b;
    logic              low;     // phase falls in the low-heat half
    logic              close;   // sample opens a new cycle
  } sample_t;

  // Queue status toward its two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sqr_front.sv =====
`default_nettype none

module sqr_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Configuration writes
  input  wire                               cfg_we_i,
  input  wire  [sqr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [sqr_pkg::CFG_W-1:0]         cfg_data_i,
  // Input words
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [sqr_pkg::TIME_W-1:0]        time_ms_i,
  input  wire  [sqr_pkg::GAS_W-1:0]         gas_a_i,
  input  wire                               ok_a_i,
  input  wire  [sqr_pkg::GAS_W-1:0]         gas_b_i,
  input  wire                               ok_b_i,
  // Toward the queue
  input  sqr_pkg::queue_stat_t              q_stat_i,
  output logic                              push_o,
  output sqr_pkg::sample_t                  sample_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [sqr_pkg::CFG_W-1:0]  period_q, half_q;
  logic [sqr_pkg::CFG_W-1:0]  per_q, per_d;
  logic [sqr_pkg::CFG_W-1:0]  rem_q, rem_d;
  logic [sqr_pkg::TIME_W-1:0] quo_q, quo_d;
  logic [sqr_pkg::STEP_W-1:0] step_q, step_d;
  logic [sqr_pkg::TIME_W-1:0] cur_cycle_q, cur_cycle_d;
  logic [sqr_pkg::TIME_W-1:0] time_q;
  logic [sqr_pkg::GAS_W-1:0]  gas_a_q, gas_b_q;
  logic                       ok_a_q, ok_b_q;
  logic [sqr_pkg::CFG_W:0]    trial;
  logic [sqr_pkg::CFG_W:0]    diff;
  logic                       ge;
  logic                       accept;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= sqr_pkg::PERIOD_MS_RST;
      half_q   <= sqr_pkg::HALF_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sqr_pkg::CFG_PERIOD_MS: period_q <= cfg_data_i;
        sqr_pkg::CFG_HALF_MS:   half_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One restoring step of time / period: the quotient bits replace the
  // time bits as they are shifted out, the remainder ends up as the phase.
  assign trial = {rem_q, quo_q[sqr_pkg::TIME_W-1]};
  assign diff  = trial - {1'b0, per_q};
  assign ge    = (trial >= {1'b0, per_q});

  always_comb begin
    state_d     = state_q;
    per_d       = per_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    cur_cycle_d = cur_cycle_q;
    push_o      = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          per_d   = (period_q == '0) ? sqr_pkg::CFG_W'(1) : period_q;
          rem_d   = '0;
          quo_d   = time_ms_i;
          step_d  = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = ge ? diff[sqr_pkg::CFG_W-1:0] : trial[sqr_pkg::CFG_W-1:0];
        quo_d  = {quo_q[sqr_pkg::TIME_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == sqr_pkg::STEP_LAST) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          push_o      = 1'b1;
          cur_cycle_d = quo_q;
          state_d     = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Classified word for the queue.
  always_comb begin
    sample_o.time_ms = time_q;
    sample_o.gas_a   = gas_a_q;
    sample_o.ok_a    = ok_a_q;
    sample_o.gas_b   = gas_b_q;
    sample_o.ok_b    = ok_b_q;
    sample_o.low     = (rem_q < half_q);
    sample_o.close   = (quo_q != cur_cycle_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      step_q      <= '0;
      cur_cycle_q <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cur_cycle_q <= cur_cycle_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    per_q <= per_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (accept) begin
      time_q  <= time_ms_i;
      gas_a_q <= gas_a_i;
      ok_a_q  <= ok_a_i;
      gas_b_q <= gas_b_i;
      ok_b_q  <= ok_b_i;
    end
  end

  // A pushed word returns the classifier to idle on the next edge.
  a_push_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (state_q == F_IDLE))
    else $error("classifier did not return to idle after a push");

endmodule

`default_nettype wire

// ===== rtl/sqr_queue.sv =====
`default_nettype none

module sqr_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  sqr_pkg::sample_t     sample_i,
  input  wire                  pop_i,
  output sqr_pkg::sample_t     sample_o,
  output sqr_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(sqr_pkg::QUEUE_DEPTH);

  sqr_pkg::sample_t mem_q [sqr_pkg::QUEUE_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign stat_o.full  = (count_q == (PtrW+1)'(sqr_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign sample_o     = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= sample_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/sqr_back.sv =====
`default_nettype none

module sqr_back #(
  parameter int unsigned MAX_SAMPLES = sqr_pkg::MAX_SAMPLES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // From the queue
  input  sqr_pkg::queue_stat_t             q_stat_i,
  input  sqr_pkg::sample_t                 sample_i,
  output logic                             pop_o,
  // Result words
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [sqr_pkg::TIME_W-1:0]       stamp_ms_o,
  output logic [sqr_pkg::RATIO_W-1:0]      ratio_a_o,
  output logic                             valid_a_o,
  output logic [sqr_pkg::RATIO_W-1:0]      ratio_b_o,
  output logic                             valid_b_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = sqr_pkg::GAS_W + $clog2(MAX_SAMPLES);
  localparam int unsigned NumW = SumW + CntW;
  localparam int unsigned QW   = sqr_pkg::RATIO_W;
  localparam int unsigned FracW = QW / 2;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_CHK  = 6'b000100,
    B_DIV  = 6'b001000,
    B_EMIT = 6'b010000,
    B_ACC  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [SumW-1:0] lsum_q [sqr_pkg::NSENS];
  logic [SumW-1:0] hsum_q [sqr_pkg::NSENS];
  logic [CntW-1:0] lcnt_q [sqr_pkg::NSENS];
  logic [CntW-1:0] hcnt_q [sqr_pkg::NSENS];
  logic [SumW-1:0] lsum_d [sqr_pkg::NSENS];
  logic [SumW-1:0] hsum_d [sqr_pkg::NSENS];
  logic [CntW-1:0] lcnt_d [sqr_pkg::NSENS];
  logic [CntW-1:0] hcnt_d [sqr_pkg::NSENS];
  logic [sqr_pkg::GAS_W-1:0] gas [sqr_pkg::NSENS];
  logic                      ok  [sqr_pkg::NSENS];

  logic [QW-1:0] res_ratio_q [sqr_pkg::NSENS];
  logic          res_vld_q   [sqr_pkg::NSENS];

  logic                       sel_q;
  logic [NumW-1:0]            num_q, den_q;
  logic                       inv_q;
  logic [NumW-1:0]            rem_q;
  logic [QW-1:0]              quo_q;
  logic [sqr_pkg::STEP_W-1:0] step_q;
  logic                       out_free;
  logic                       saturate;
  logic [NumW:0]              trial, diff;
  logic                       ge;

  assign out_free = !out_valid_o || out_ready_i;
  assign saturate = ({{FracW{1'b0}}, num_q} >= {den_q, {FracW{1'b0}}});
  assign trial    = {rem_q, quo_q[QW-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = (trial >= {1'b0, den_q});

  assign gas[0] = sample_i.gas_a;
  assign gas[1] = sample_i.gas_b;
  assign ok[0]  = sample_i.ok_a;
  assign ok[1]  = sample_i.ok_b;

  // Sequencer: ratios for both sensors on a closing word, then accumulate.
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = sample_i.close ? B_MUL : B_ACC;
        end
      end
      B_MUL: state_d = B_CHK;
      B_CHK: begin
        if (inv_q || saturate) begin
          state_d = sel_q ? B_EMIT : B_MUL;
        end else begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (step_q == sqr_pkg::STEP_LAST) begin
          state_d = sel_q ? B_EMIT : B_MUL;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_d = B_ACC;
        end
      end
      B_ACC: begin
        pop_o   = 1'b1;
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Window update: a closing word clears the window before it is added.
  always_comb begin
    for (int s = 0; s < sqr_pkg::NSENS; s++) begin
      lsum_d[s] = lsum_q[s];
      hsum_d[s] = hsum_q[s];
      lcnt_d[s] = lcnt_q[s];
      hcnt_d[s] = hcnt_q[s];
      if (state_q == B_ACC) begin
        if (sample_i.close) begin
          lsum_d[s] = '0;
          hsum_d[s] = '0;
          lcnt_d[s] = '0;
          hcnt_d[s] = '0;
        end
        if (ok[s]) begin
          if (sample_i.low) begin
            if (lcnt_d[s] < CntMax) begin
              lsum_d[s] = lsum_d[s] + SumW'(gas[s]);
              lcnt_d[s] = lcnt_d[s] + 1'b1;
            end
          end else begin
            if (hcnt_d[s] < CntMax) begin
              hsum_d[s] = hsum_d[s] + SumW'(gas[s]);
              hcnt_d[s] = hcnt_d[s] + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_o <= 1'b0;
      sel_q       <= 1'b0;
      step_q      <= '0;
      for (int s = 0; s < sqr_pkg::NSENS; s++) begin
        lsum_q[s] <= '0;
        hsum_q[s] <= '0;
        lcnt_q[s] <= '0;
        hcnt_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      for (int s = 0; s < sqr_pkg::NSENS; s++) begin
        lsum_q[s] <= lsum_d[s];
        hsum_q[s] <= hsum_d[s];
        lcnt_q[s] <= lcnt_d[s];
        hcnt_q[s] <= hcnt_d[s];
      end
      // Output register handshake.
      if (state_q == B_EMIT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      // Sensor select and divider step count.
      if (state_q == B_IDLE) begin
        sel_q <= 1'b0;
      end else if ((state_q == B_CHK && (inv_q || saturate)) ||
                   (state_q == B_DIV && step_q == sqr_pkg::STEP_LAST)) begin
        sel_q <= 1'b1;
      end
      if (state_q == B_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Ratio datapath: cross products, then floor(num * 2^16 / den) bit by bit.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_MUL: begin
        num_q <= NumW'(hsum_q[sel_q]) * NumW'(lcnt_q[sel_q]);
        den_q <= NumW'(lsum_q[sel_q]) * NumW'(hcnt_q[sel_q]);
        inv_q <= (lcnt_q[sel_q] == '0) || (hcnt_q[sel_q] == '0) ||
                 (lsum_q[sel_q] == '0);
      end
      B_CHK: begin
        if (inv_q) begin
          res_ratio_q[sel_q] <= '0;
          res_vld_q[sel_q]   <= 1'b0;
        end else if (saturate) begin
          res_ratio_q[sel_q] <= '1;
          res_vld_q[sel_q]   <= 1'b1;
        end
        rem_q <= {{FracW{1'b0}}, num_q[NumW-1:FracW]};
        quo_q <= {num_q[FracW-1:0], {FracW{1'b0}}};
      end
      B_DIV: begin
        rem_q <= ge ? diff[NumW-1:0] : trial[NumW-1:0];
        quo_q <= {quo_q[QW-2:0], ge};
        if (step_q == sqr_pkg::STEP_LAST) begin
          res_ratio_q[sel_q] <= {quo_q[QW-2:0], ge};
          res_vld_q[sel_q]   <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == B_EMIT && out_free) begin
      stamp_ms_o <= sample_i.time_ms;
      ratio_a_o  <= res_ratio_q[0];
      valid_a_o  <= res_vld_q[0];
      ratio_b_o  <= res_ratio_q[1];
      valid_b_o  <= res_vld_q[1];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcnt_q[0] <= CntMax) && (hcnt_q[0] <= CntMax) &&
    (lcnt_q[1] <= CntMax) && (hcnt_q[1] <= CntMax))
    else $error("window count beyond capacity");

  a_emit_then_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT && out_free) |=> (pop_o && out_valid_o))
    else $error("result loaded without retiring its word");

endmodule

`default_nettype wire

// ===== rtl/square_wave_phase_ratio.sv =====
`default_nettype none

// Square-wave phase ratio for two temperature-modulated gas sensors. Each
// input word is a timestamped pair of sensor readings. The classifier splits
// the time into cycle and phase with a 32-step shift-subtract divider and
// takes a new word only after the last one is pushed. Classified words wait
// in a two-entry queue for the accumulator, which takes a word that stays in
// the current cycle through its idle and accumulate states. A word that
// opens a new cycle first produces one result word (per sensor: high-half
// mean over low-half mean, unsigned Q16.16, saturated to all ones) through a
// shared 32-step divider, waits for the result register to be free, then
// starts the new window. Sums and counts hold at most MAX_SAMPLES readings
// per sensor and half. Configuration, through cfg_we_i/cfg_idx_i/cfg_data_i,
// is to be written only while the block is idle; the block does not enforce
// this. Index 0 is period_ms (reset 200), index 1 is half_ms (reset 100).
module square_wave_phase_ratio #(
  parameter int unsigned MAX_SAMPLES = sqr_pkg::MAX_SAMPLES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [sqr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [sqr_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [sqr_pkg::TIME_W-1:0]       time_ms_i,
  input  wire  [sqr_pkg::GAS_W-1:0]        gas_a_i,
  input  wire                              ok_a_i,
  input  wire  [sqr_pkg::GAS_W-1:0]        gas_b_i,
  input  wire                              ok_b_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [sqr_pkg::TIME_W-1:0]       stamp_ms_o,
  output logic [sqr_pkg::RATIO_W-1:0]      ratio_a_o,
  output logic                             valid_a_o,
  output logic [sqr_pkg::RATIO_W-1:0]      ratio_b_o,
  output logic                             valid_b_o
);

  sqr_pkg::queue_stat_t q_stat;
  sqr_pkg::sample_t     push_sample, head_sample;
  logic                 push, pop;

  // Classifier: cycle and phase of each word.
  sqr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .time_ms_i  (time_ms_i),
    .gas_a_i    (gas_a_i),
    .ok_a_i     (ok_a_i),
    .gas_b_i    (gas_b_i),
    .ok_b_i     (ok_b_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .sample_o   (push_sample)
  );

  // Queue between classifier and accumulator.
  sqr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (push_sample),
    .pop_i    (pop),
    .sample_o (head_sample),
    .stat_o   (q_stat)
  );

  // Accumulator and ratio unit.
  sqr_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .sample_i    (head_sample),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stamp_ms_o  (stamp_ms_o),
    .ratio_a_o   (ratio_a_o),
    .valid_a_o   (valid_a_o),
    .ratio_b_o   (ratio_b_o),
    .valid_b_o   (valid_b_o)
  );

endmodule

`default_nettype wire
